// File: hw/rtl/signed_int_to_decimal_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication
`define SITDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants, types and helpers of the decimal ASCII unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sitda_pkg;

  // Widths and counts
  localparam int MagW       = 32;
  localparam int NumDigits  = 10;
  localparam int DigitW     = 4;
  localparam int BcdW       = NumDigits * DigitW;
  localparam int IdxW       = $clog2(NumDigits);
  localparam int StepW      = $clog2(MagW);
  localparam int CharW      = 8;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // Shift-and-add-3 constants
  localparam logic [DigitW-1:0] DigitMax    = 4'd9;
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  // Classified item: sign and unsigned magnitude
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } sitda_item_t;

  // Converted item: sign and packed BCD digits, least significant digit low
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
  } sitda_bcd_t;

  // True when every BCD digit is a legal decimal digit
  function automatic logic bcd_ok(input logic [BcdW-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitW +: DigitW] > DigitMax) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// File: hw/rtl/sitda_front.sv
// ----------------------------------------------------------------------------
// sitda_front
// Input stage: takes one integer, splits it into sign and magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitda_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic signed [sitda_pkg::MagW-1:0] in_value_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output sitda_pkg::sitda_item_t    out_item_o,
  input  logic                      out_ready_i
);

  logic                   valid_q;
  sitda_pkg::sitda_item_t item_q;
  sitda_pkg::sitda_item_t item_d;

  // Sign and magnitude; the most negative value maps to 2^31 unsigned
  always_comb begin
    item_d.neg = in_value_i[sitda_pkg::MagW-1];
    item_d.mag = item_d.neg ? sitda_pkg::MagW'(~$unsigned(in_value_i) + 1'b1)
                            : $unsigned(in_value_i);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // Holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      item_q  <= '0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
      item_q  <= item_d;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/sitda_queue.sv
// ----------------------------------------------------------------------------
// sitda_queue
// Short FIFO of classified items between front and converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitda_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sitda_pkg::sitda_item_t data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output sitda_pkg::sitda_item_t data_o,
  output logic                   empty_o
);

  sitda_pkg::sitda_item_t                 mem_q [sitda_pkg::QueueDepth];
  logic [sitda_pkg::QueuePtrW-1:0]        wr_ptr_q;
  logic [sitda_pkg::QueuePtrW-1:0]        rd_ptr_q;
  logic [sitda_pkg::QueueCntW-1:0]        count_q;
  logic                                   do_push;
  logic                                   do_pop;

  assign full_o  = (count_q == sitda_pkg::QueueCntW'(sitda_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers, fill count and storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      for (int i = 0; i < sitda_pkg::QueueDepth; i++) mem_q[i] <= '0;
    end else begin
      if (do_push) begin
        mem_q[wr_ptr_q] <= data_i;
        wr_ptr_q <= (wr_ptr_q == sitda_pkg::QueuePtrW'(sitda_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == sitda_pkg::QueuePtrW'(sitda_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// File: hw/rtl/sitda_bcd.sv
// ----------------------------------------------------------------------------
// sitda_bcd
// Binary to BCD converter, shift-and-add-3, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitda_bcd (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  sitda_pkg::sitda_item_t in_item_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output sitda_pkg::sitda_bcd_t  out_data_o,
  input  logic                   out_ready_i
);

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StDone
  } state_e;

  state_e                          state_q;
  logic                            neg_q;
  logic [sitda_pkg::MagW-1:0]      bin_q;
  logic [sitda_pkg::MagW-1:0]      bin_d;
  logic [sitda_pkg::BcdW-1:0]      bcd_q;
  logic [sitda_pkg::BcdW-1:0]      bcd_d;
  logic [sitda_pkg::BcdW-1:0]      adj;
  logic [sitda_pkg::StepW-1:0]     step_q;

  // One step: correct digits of five or more, then shift in the next bit
  always_comb begin
    logic [sitda_pkg::DigitW-1:0] d;
    d = '0;
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      d = bcd_q[i*sitda_pkg::DigitW +: sitda_pkg::DigitW];
      adj[i*sitda_pkg::DigitW +: sitda_pkg::DigitW] =
        (d >= sitda_pkg::DabbleLimit) ? d + sitda_pkg::DabbleAdd : d;
    end
    {bcd_d, bin_d} = {adj[sitda_pkg::BcdW-2:0], bin_q, 1'b0};
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = (state_q == StDone);
  assign out_data_o.neg = neg_q;
  assign out_data_o.bcd = bcd_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      neg_q   <= 1'b0;
      bin_q   <= '0;
      bcd_q   <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            neg_q   <= in_item_i.neg;
            bin_q   <= in_item_i.mag;
            bcd_q   <= '0;
            step_q  <= '0;
            state_q <= StShift;
          end
        end
        StShift: begin
          bin_q  <= bin_d;
          bcd_q  <= bcd_d;
          step_q <= step_q + 1'b1;
          if (step_q == sitda_pkg::StepW'(sitda_pkg::MagW - 1)) state_q <= StDone;
        end
        StDone: begin
          if (out_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: hw/rtl/sitda_emit.sv
// ----------------------------------------------------------------------------
// sitda_emit
// Character sequencer: sign, then digits from the leading one, one a cycle while the output is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitda_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  sitda_pkg::sitda_bcd_t         in_data_i,
  output logic                          in_ready_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [sitda_pkg::CharW-1:0]   char_code_o,
  output logic                          last_char_o
);

  typedef enum logic [1:0] {
    EmIdle,
    EmSign,
    EmDigits
  } state_e;

  state_e                          state_q;
  logic [sitda_pkg::DigitW-1:0]    digits_q [sitda_pkg::NumDigits];
  logic [sitda_pkg::IdxW-1:0]      idx_q;
  logic [sitda_pkg::IdxW-1:0]      top_idx;
  logic [sitda_pkg::DigitW-1:0]    cur_digit;
  logic                            out_valid_q;
  logic [sitda_pkg::CharW-1:0]     char_q;
  logic                            last_q;
  logic                            adv;

  // Highest non-zero digit; zero itself prints one digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (in_data_i.bcd[i*sitda_pkg::DigitW +: sitda_pkg::DigitW] != '0) begin
        top_idx = sitda_pkg::IdxW'(i);
      end
    end
  end

  assign cur_digit   = digits_q[idx_q];
  assign adv         = !out_valid_q || pop_i;
  assign in_ready_o  = (state_q == EmIdle);
  assign empty_o     = !out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EmIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      for (int i = 0; i < sitda_pkg::NumDigits; i++) digits_q[i] <= '0;
    end else begin
      if (adv) out_valid_q <= (state_q != EmIdle);
      case (state_q)
        EmIdle: begin
          if (in_valid_i) begin
            for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
              digits_q[i] <= in_data_i.bcd[i*sitda_pkg::DigitW +: sitda_pkg::DigitW];
            end
            idx_q   <= top_idx;
            state_q <= in_data_i.neg ? EmSign : EmDigits;
          end
        end
        EmSign: begin
          if (adv) begin
            char_q  <= sitda_pkg::CharMinus;
            last_q  <= 1'b0;
            state_q <= EmDigits;
          end
        end
        EmDigits: begin
          if (adv) begin
            char_q <= sitda_pkg::CharZero + sitda_pkg::CharW'(cur_digit);
            last_q <= (idx_q == '0);
            if (idx_q == '0) state_q <= EmIdle;
            else             idx_q   <= idx_q - 1'b1;
          end
        end
        default: state_q <= EmIdle;
      endcase
    end
  end

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: 32-bit signed integer to decimal ASCII
// Output: characters follow one per cycle while the consumer keeps popping.
// Pacing: set by the 32-step BCD converter, which takes no new item until its result is taken.
// Reset: asynchronous, clears the front, queue, converter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [sitda_pkg::MagW-1:0] value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [sitda_pkg::CharW-1:0]       char_code_o,
  output logic                              last_char_o
);

`include "signed_int_to_decimal_ascii_unit_assert.svh"

  logic                   front_ready;
  logic                   front_valid;
  sitda_pkg::sitda_item_t front_item;
  logic                   q_full;
  logic                   q_empty;
  sitda_pkg::sitda_item_t q_item;
  logic                   conv_ready;
  logic                   conv_valid;
  sitda_pkg::sitda_bcd_t  conv_data;
  logic                   emit_ready;
  logic                   char_minus;
  logic                   char_legal;

  assign full = !front_ready;

  // Front: classify
  sitda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_value_i  (value_i),
    .in_ready_o  (front_ready),
    .out_valid_o (front_valid),
    .out_item_o  (front_item),
    .out_ready_i (!q_full)
  );

  // Decoupling queue
  sitda_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (q_full),
    .pop_i   (conv_ready),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  // Back: binary to BCD
  sitda_bcd u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_item_i   (q_item),
    .in_ready_o  (conv_ready),
    .out_valid_o (conv_valid),
    .out_data_o  (conv_data),
    .out_ready_i (emit_ready)
  );

  // Back: character output
  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (conv_valid),
    .in_data_i   (conv_data),
    .in_ready_o  (emit_ready),
    .empty_o     (empty),
    .pop_i       (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  // Character classes for the checks
  assign char_minus = (char_code_o == sitda_pkg::CharMinus);
  assign char_legal = char_minus || ((char_code_o >= sitda_pkg::CharZero) &&
                                     (char_code_o <= sitda_pkg::CharNine));

  // Checks
  `SITDA_ASSERT_IMPL(a_char_legal, !empty, char_legal, "illegal character code")
  `SITDA_ASSERT_IMPL(a_minus_not_last, !empty && char_minus, !last_char_o, "minus flagged last")
  `SITDA_ASSERT_IMPL(a_bcd_digits, conv_valid, sitda_pkg::bcd_ok(conv_data.bcd), "bad BCD digit")
  `SITDA_ASSERT_NEXT(a_emit_busy, conv_valid && emit_ready, !emit_ready, "emitter still idle")

endmodule

// File: tb/signed_int_to_decimal_ascii_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_test
// Feeds signed 32-bit integers into the decimal ASCII unit and checks every
// character it emits against a predicted text, in order, with random gaps on
// both the push and the pop side.
// ----------------------------------------------------------------------------

module signed_int_to_decimal_ascii_unit_test;

  import sitda_pkg::*;

  localparam int unsigned Radix      = 10;
  localparam int          IdleLimit  = 4000;
  localparam int          SettleCyc  = 60;
  localparam int          NumRandom  = 400;
  localparam int          MaxReports = 10;

  // One input item waiting to be sent; drain_first holds it back until
  // every character already predicted has been popped
  typedef struct {
    logic signed [MagW-1:0] value;
    logic                   drain_first;
  } number_item_t;

  // One expected character
  typedef struct {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   push  = 1'b0;
  logic signed [MagW-1:0] value = '0;
  logic                   pop   = 1'b0;
  logic                   full;
  logic                   empty;
  logic [CharW-1:0]       char_code;
  logic                   last_char;

  number_item_t numbers_pending[$];
  text_char_t   text_expected[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int tx_gap         = 0;
  int rx_gap         = 0;
  bit tx_calm        = 1'b0;
  bit rx_calm        = 1'b0;

  signed_int_to_decimal_ascii_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code),
    .last_char_o (last_char)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Decimal text of one number: sign first, then digits, most significant first
  function automatic void predict_text(input logic signed [MagW-1:0] num);
    logic            neg;
    logic [MagW-1:0] mag;
    logic [3:0]      digits[NumDigits];
    int              ndig;
    text_char_t      ch;
    neg  = num[MagW-1];
    // unsigned negate, so the most negative value keeps its full magnitude
    mag  = neg ? (32'd0 - $unsigned(num)) : $unsigned(num);
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % Radix);
      ndig++;
      mag = mag / Radix;
    end while (mag != 0 && ndig < NumDigits);
    if (neg) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      text_expected.push_back(ch);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.code = CharZero + CharW'(digits[k]);
      ch.last = (k == 0);
      text_expected.push_back(ch);
    end
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random value: raw bits, a chosen digit count, near zero, or near the ends
  function automatic logic signed [MagW-1:0] random_number();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: begin
        n   = $urandom_range(1, NumDigits);
        lo  = (n == 1) ? 0 : longint'(10) ** (n - 1);
        hi  = (longint'(10) ** n) - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return $urandom_range(0, 1) ? -MagW'(mag) : MagW'(mag);
      end
      3: return $signed(MagW'($urandom_range(0, 40))) - 20;
      default: begin
        if ($urandom_range(0, 1))
          return 32'sh7fff_ffff - $signed(MagW'($urandom_range(0, 15)));
        return 32'sh8000_0000 + $signed(MagW'($urandom_range(0, 15)));
      end
    endcase
  endfunction

  // Driver: holds push until the item is taken, then picks the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_text(value);
      if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
      if (!push || !full) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (numbers_pending.size() != 0 &&
                     !(numbers_pending[0].drain_first && text_expected.size() != 0)) begin
          value  <= numbers_pending[0].value;
          push   <= 1'b1;
          tx_gap  = pick_gap(tx_calm);
          void'(numbers_pending.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each popped character, then decides the next pop
  always @(posedge clk_i) begin
    text_char_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (text_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: unexpected character %h last %b", $realtime, char_code, last_char);
        end else begin
          want = text_expected.pop_front();
          if (char_code !== want.code || last_char !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display("%0t: character mismatch: expected %h last %b, got %h last %b",
                       $realtime, want.code, want.last, char_code, last_char);
          end
        end
      end
      if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop   <= 1'b1;
        rx_gap = pick_gap(rx_calm);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic signed [MagW-1:0] directed[$];
    number_item_t           item;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001,
                 32'sd1000000000, 32'sd999999999, -32'sd999999999,
                 32'sd1234567890, -32'sd1234567890, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sd7, -32'sd5};
    foreach (directed[i]) begin
      item.value       = directed[i];
      item.drain_first = 1'b0;
      numbers_pending.push_back(item);
    end
    for (int i = 0; i < NumRandom; i++) begin
      item.value = random_number();
      // sender waits for the unit to empty now and then
      item.drain_first = (i == 0) || (i % 97 == 50);
      numbers_pending.push_back(item);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (numbers_pending.size() != 0 || push || text_expected.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);

    if (text_expected.size() != 0) begin
      mismatch_count++;
      $display("%0d expected characters never arrived", text_expected.size());
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
